### rtl/sts_pkg.sv
// Shared constants and types for the sorted key table.
package sts_pkg;

    localparam int DEPTH     = 256;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam key_t KEY_SIGN = key_t'(1) << (KEY_WIDTH - 1);
    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

endpackage

### rtl/sorted_table_search_insert.sv
// Sorted key table: binary search and sorted insert over one key memory.
//
//  channel  direction  handshake              word
//  in       input      in_valid / in_stall    mode, key
//  out      output     out_valid / out_stall  found, position, status, entry_count
//  cfg      input      cfg_we                 cfg_wdata (compare_signed)
//
// One item at a time. The search takes up to log2(DEPTH)+1 probes, each a check state and a
// compare state, since each probe waits on the registered key memory read; the closing check,
// place and done states follow before the result is valid.
// An insert moves each later entry up one place in the shift state, through one read and one write port.
// Reset clears the count, the ordering register and the control state; keys stay undefined.
// A held result does not block acceptance of the next word, only its completion.
module sorted_table_search_insert
    import sts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [31:0]          key,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [CNT_W-1:0]     position,
    output logic                 status,
    output logic [CNT_W-1:0]     entry_count,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    key_t key_mem [DEPTH];

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    logic       signed_reg;
    logic       mode_reg, mode_next;
    key_t       key_reg, key_next;
    cnt_t       lo_reg, lo_next;
    cnt_t       hi_reg, hi_next;
    cnt_t       mid_reg, mid_next;
    cnt_t       pos_reg, pos_next;
    cnt_t       sh_reg, sh_next;
    logic       hit_reg, hit_next;
    key_t       rd_data_reg;

    logic       out_valid_reg, out_valid_next;
    logic       found_reg, found_next;
    cnt_t       position_reg, position_next;
    logic       status_reg, status_next;
    cnt_t       entry_count_reg, entry_count_next;

    logic       rd_en;
    addr_t      rd_addr;
    logic       wr_en;
    addr_t      wr_addr;
    key_t       wr_data;

    cnt_t       probe;
    cnt_t       clamp_mid;
    cnt_t       sh_dec;
    key_t       cmp_a, cmp_b;
    logic       full;
    logic       do_insert;
    logic       slot_free;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    assign probe     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign clamp_mid = (mid_reg > count_reg) ? count_reg : mid_reg;
    assign sh_dec    = sh_reg - cnt_t'(1);
    assign full      = (count_reg == CNT_FULL);
    assign do_insert = mode_reg && !full;
    assign slot_free = !out_valid_reg || !out_stall;

    // Flip the sign bit so that a plain unsigned compare orders two's complement keys.
    assign cmp_a = signed_reg ? (key_reg ^ KEY_SIGN) : key_reg;
    assign cmp_b = signed_reg ? (rd_data_reg ^ KEY_SIGN) : rd_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        pos_next         = pos_reg;
        sh_next          = sh_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        position_next    = position_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        rd_en            = 1'b0;
        rd_addr          = probe[ADDR_W-1:0];
        wr_en            = 1'b0;
        wr_addr          = pos_reg[ADDR_W-1:0];
        wr_data          = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    key_next   = key[KEY_WIDTH-1:0];
                    lo_next    = '0;
                    hi_next    = count_reg;
                    mid_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (hi_reg == lo_reg)
                begin
                    pos_next   = clamp_mid;
                    sh_next    = count_reg;
                    state_next = S_PLACE;
                end
                else
                begin
                    mid_next   = probe;
                    rd_en      = 1'b1;
                    rd_addr    = probe[ADDR_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmp_a < cmp_b)
                begin
                    hi_next    = mid_reg;
                    state_next = S_CHECK;
                end
                else if (cmp_a > cmp_b)
                begin
                    // Window of one entry: the insertion point lies just above it.
                    if (lo_reg == mid_reg)
                    begin
                        mid_next = lo_reg + cnt_t'(1);
                        hi_next  = lo_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg;
                    end
                    state_next = S_CHECK;
                end
                else
                begin
                    hit_next   = 1'b1;
                    pos_next   = clamp_mid;
                    sh_next    = count_reg;
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (do_insert && (sh_reg != pos_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sh_dec[ADDR_W-1:0];
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                // Write the entry read last cycle one place up; fetch the next one below.
                wr_en   = 1'b1;
                wr_addr = sh_reg[ADDR_W-1:0];
                wr_data = rd_data_reg;
                sh_next = sh_dec;
                if (sh_dec != pos_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(sh_dec - cnt_t'(1));
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    if (do_insert)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg[ADDR_W-1:0];
                        wr_data    = key_reg;
                        count_next = count_reg + cnt_t'(1);
                    end
                    out_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    position_next    = pos_reg;
                    status_next      = mode_reg && full;
                    entry_count_next = do_insert ? (count_reg + cnt_t'(1)) : count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            signed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                signed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        pos_reg         <= pos_next;
        sh_reg          <= sh_next;
        hit_reg         <= hit_next;
        found_reg       <= found_next;
        position_reg    <= position_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

endmodule

### test/sts_tb_pkg.sv
`timescale 1ns / 1ps
// Word codes shared by the sorted key table checker and testbench top.
package sts_tb_pkg;

    typedef enum logic {MODE_SEARCH = 1'b0, MODE_INSERT = 1'b1} word_mode_e;
    typedef enum logic {STATUS_DONE = 1'b0, STATUS_FULL = 1'b1} table_status_e;
    typedef enum logic {ORDER_UNSIGNED = 1'b0, ORDER_SIGNED = 1'b1} key_order_e;

endpackage

### test/sts_result_checker.sv
`timescale 1ns / 1ps
// Channel monitor for the sorted key table: predicts each result word and compares it.
module sts_result_checker
    import sts_pkg::*;
    import sts_tb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             mode,
    input  logic [31:0]      key,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic             found,
    input  logic [CNT_W-1:0] position,
    input  logic             status,
    input  logic [CNT_W-1:0] entry_count,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    output int               mismatches,
    output int               pending_results,
    output int               checked_words,
    output int               hits_seen,
    output int               refusals_seen
);

    typedef struct {
        logic          hit;
        cnt_t          pos_lo;
        cnt_t          pos_hi;
        table_status_e status;
        cnt_t          held_after;
    } lookup_t;

    key_t       stored_keys [DEPTH];
    int         held;
    key_order_e key_order;
    lookup_t    due_results [$];
    lookup_t    oldest;
    int         fails;
    int         checked;
    int         hits;
    int         refusals;

    function automatic int key_rank(key_t a, key_t b);
        key_t x;
        key_t y;
        x = (key_order == ORDER_SIGNED) ? (a ^ KEY_SIGN) : a;
        y = (key_order == ORDER_SIGNED) ? (b ^ KEY_SIGN) : b;
        if (x < y)
            return -1;
        if (x > y)
            return 1;
        return 0;
    endfunction

    // Binary search over the held keys, then the sorted insert when asked for.
    function automatic lookup_t search_and_insert(word_mode_e m, key_t k);
        lookup_t r;
        int lo;
        int hi;
        int mid;
        int ord;
        int pos;
        int i;
        lo  = 0;
        hi  = held;
        mid = 0;
        ord = -1;
        while (hi != lo && ord != 0)
        begin
            mid = lo + ((hi - lo) >> 1);
            ord = key_rank(k, stored_keys[mid]);
            if (ord < 0)
                hi = mid;
            else if (ord > 0)
            begin
                if (lo == mid)
                begin
                    mid = lo + 1;
                    hi  = lo;
                end
                else
                    lo = mid;
            end
        end
        pos      = (mid > held) ? held : mid;
        r.hit    = (ord == 0);
        r.pos_lo = cnt_t'(pos);
        r.pos_hi = cnt_t'(pos);
        // Any copy within a run of equal keys is a valid report; the table ends up the same.
        if (r.hit)
        begin
            lo = pos;
            hi = pos;
            while (lo > 0 && stored_keys[lo-1] == k)
                lo--;
            while (hi < held - 1 && stored_keys[hi+1] == k)
                hi++;
            r.pos_lo = cnt_t'(lo);
            r.pos_hi = cnt_t'(hi);
        end
        r.status = STATUS_DONE;
        if (m == MODE_INSERT)
        begin
            if (held >= DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                for (i = held; i > pos; i--)
                    stored_keys[i] = stored_keys[i-1];
                stored_keys[pos] = k;
                held++;
            end
        end
        r.held_after = cnt_t'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held      = 0;
            key_order = ORDER_UNSIGNED;
            fails     = 0;
            checked   = 0;
            hits      = 0;
            refusals  = 0;
            due_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: found=%0d position=%0d status=%0d entry_count=%0d",
                             $time, found, position, status, entry_count);
                    fails++;
                end
                else
                begin
                    oldest = due_results.pop_front();
                    checked++;
                    if (found !== oldest.hit)
                    begin
                        $display("%0t: found expected %0d actual %0d", $time, oldest.hit, found);
                        fails++;
                    end
                    if ($isunknown(position) || position < oldest.pos_lo
                        || position > oldest.pos_hi)
                    begin
                        $display("%0t: position expected %0d..%0d actual %0d",
                                 $time, oldest.pos_lo, oldest.pos_hi, position);
                        fails++;
                    end
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                        fails++;
                    end
                    if (entry_count !== oldest.held_after)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, oldest.held_after, entry_count);
                        fails++;
                    end
                    if (oldest.hit)
                        hits++;
                    if (oldest.status == STATUS_FULL)
                        refusals++;
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(search_and_insert(word_mode_e'(mode), key_t'(key)));
            if (cfg_we)
                key_order = key_order_e'(cfg_wdata);
        end
        mismatches      <= fails;
        pending_results <= due_results.size();
        checked_words   <= checked;
        hits_seen       <= hits;
        refusals_seen   <= refusals;
    end

endmodule

### test/tb_sorted_table_search_insert.sv
`timescale 1ns / 1ps
// Testbench top for the sorted key table: stimulus, idling and the verdict.
module tb_sorted_table_search_insert;
    import sts_pkg::*;
    import sts_tb_pkg::*;

    localparam int LIMIT    = 2_000_000;
    localparam int END_WAIT = 2 * ADDR_W + 3 + DEPTH + 2;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       in_mode      = MODE_SEARCH;
    key_t       in_key       = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       res_found;
    cnt_t       res_position;
    logic       res_status;
    cnt_t       res_count;
    logic       cfg_we       = 1'b0;
    logic       cfg_wdata    = ORDER_UNSIGNED;

    int         mismatches;
    int         pending_results;
    int         checked_words;
    int         hits_seen;
    int         refusals_seen;

    int         send_idle    = 0;
    int         recv_idle    = 0;
    int         inserts_sent = 0;
    int         cycles       = 0;
    key_t       key_pool [$];

    sorted_table_search_insert DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (in_mode),
        .key         (in_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (res_found),
        .position    (res_position),
        .status      (res_status),
        .entry_count (res_count),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    sts_result_checker result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (in_mode),
        .key             (in_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (res_found),
        .position        (res_position),
        .status          (res_status),
        .entry_count     (res_count),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .checked_words   (checked_words),
        .hits_seen       (hits_seen),
        .refusals_seen   (refusals_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic word_mode_e pick_mode(int insert_pct);
        return ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_SEARCH;
    endfunction

    // Mostly held keys and their neighbours, some extremes, the rest anything.
    function automatic key_t pick_key();
        int   roll;
        key_t base;
        roll = $urandom_range(99);
        if (key_pool.size() != 0 && roll < 60)
        begin
            base = key_pool[$urandom_range(key_pool.size() - 1)];
            if (roll < 40)
                return base;
            return (roll < 50) ? base + 1 : base - 1;
        end
        if (roll < 70)
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return KEY_SIGN;
                default: return ~KEY_SIGN;
            endcase
        end
        return key_t'($urandom());
    endfunction

    // Present one word and hold it until taken; valid stays high for a back-to-back word.
    task automatic send_word(input word_mode_e m, input key_t k);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= m;
        in_key   <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == MODE_INSERT)
        begin
            if (inserts_sent < DEPTH)
                key_pool.push_back(k);
            inserts_sent++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_order(input key_order_e o);
        cfg_we    <= 1'b1;
        cfg_wdata <= o;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 25;
        recv_idle = 56;
        write_order(ORDER_UNSIGNED);

        // Empty table, single entry, extremes and a run of duplicates.
        send_word(MODE_SEARCH, 32'h0000_0000);
        send_word(MODE_SEARCH, 32'hFFFF_FFFF);
        send_word(MODE_INSERT, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h9000_0000);
        send_word(MODE_SEARCH, 32'h0000_0001);
        send_word(MODE_INSERT, 32'hFFFF_FFFF);
        send_word(MODE_INSERT, 32'h0000_0000);
        send_word(MODE_INSERT, 32'h7FFF_FFFF);
        send_word(MODE_INSERT, 32'h7FFF_FFFF);
        send_word(MODE_INSERT, 32'h7FFF_FFFF);
        send_word(MODE_SEARCH, 32'h7FFF_FFFF);
        send_word(MODE_SEARCH, 32'h0000_0000);
        send_word(MODE_SEARCH, 32'hFFFF_FFFF);
        send_word(MODE_SEARCH, 32'h7FFF_FFFE);
        send_word(MODE_SEARCH, 32'h8000_0001);
        send_word(MODE_INSERT, 32'h5555_5555);
        send_word(MODE_INSERT, 32'hAAAA_AAAA);
        send_word(MODE_SEARCH, 32'hAAAA_AAAA);
        send_word(MODE_SEARCH, 32'h5555_5554);

        repeat (240)
            send_word(pick_mode(40), pick_key());
        drain();

        // Signed ordering over a table sorted unsigned: searches run on the order as held.
        send_idle = 56;
        recv_idle = 25;
        write_order(ORDER_SIGNED);
        repeat (220)
            send_word(pick_mode(40), pick_key());
        drain();

        // Fill the table, then keep going against a full table.
        send_idle = 0;
        recv_idle = 0;
        write_order(ORDER_UNSIGNED);
        while (inserts_sent < DEPTH)
            send_word(pick_mode(80), pick_key());
        repeat (120)
            send_word(pick_mode(50), pick_key());
        drain();
        repeat (END_WAIT) @(posedge clk);

        $display("Checked %0d words: %0d found a held key, %0d inserts refused on a full table.",
                 checked_words, hits_seen, refusals_seen);
        $display("Orderings covered: unsigned, signed over unsigned-sorted keys, unsigned again.");
        if (mismatches == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending_results);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/sts_pkg.sv
rtl/sorted_table_search_insert.sv
test/sts_tb_pkg.sv
test/sts_result_checker.sv
test/tb_sorted_table_search_insert.sv
